FILE: design/lir_pkg.sv
// Shared types and constants for the linear interpolation resampler.
// No dependencies; imported by the front end, the back end and the top level.

package lir_pkg;

  // Integer bits of the step and phase words above the fraction: five, enough
  // for the largest step of 16.0 and so that a phase plus a step never overflows.
  localparam int STEP_INT_BITS = 5;

  // Classification of one queued input word.
  typedef struct packed {
    logic first;  // No previous sample existed in this buffer.
    logic fin;    // The word closes the buffer.
  } lir_ctl_t;

endpackage

FILE: design/lir_fifo.sv
// Two-entry command queue between the resampler front and back ends.
// Depends on nothing; the payload width is a parameter.

module lir_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: design/lir_front.sv
// Front end of the resampler: accepts input words, keeps the previous sample
// and the step register, and queues one classified command per word. Uses lir_pkg.

module lir_front
  import lir_pkg::*;
#(
  parameter int SAMPLE_BITS  = 24,
  parameter int FRAC_BITS    = 16,
  parameter int MAX_UPSAMPLE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic                                in_final_req,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [FRAC_BITS+STEP_INT_BITS-1:0]  cfg_step,
  output logic                                q_valid,
  input  logic                                q_ready,
  output lir_ctl_t                            q_ctl,
  output logic signed [SAMPLE_BITS-1:0]       q_a,
  output logic signed [SAMPLE_BITS:0]         q_diff,
  output logic [FRAC_BITS+STEP_INT_BITS-1:0]  q_step
);

  localparam int STEP_W = FRAC_BITS + STEP_INT_BITS;
  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(2 ** FRAC_BITS);
  localparam logic [STEP_W-1:0] STEP_MIN =
    STEP_W'((2 ** FRAC_BITS + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE);
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(2 ** (FRAC_BITS + 4));

  logic [STEP_W-1:0]             step_r;
  logic signed [SAMPLE_BITS-1:0] prev_r, prev_nxt;
  logic                          have_prev_r, have_prev_nxt;
  logic                          accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = q_ready;
  assign q_valid   = in_valid;
  assign accept    = in_valid && q_ready;

  assign q_ctl.first = !have_prev_r;
  assign q_ctl.fin   = in_final_req;
  assign q_a         = prev_r;
  assign q_diff      = $signed({in_sample[SAMPLE_BITS-1], in_sample})
                     - $signed({prev_r[SAMPLE_BITS-1], prev_r});

  // Out-of-range steps are clamped so that one interval yields at most
  // MAX_UPSAMPLE results.
  always_comb begin
    if (step_r < STEP_MIN) begin
      q_step = STEP_MIN;
    end else if (step_r > STEP_MAX) begin
      q_step = STEP_MAX;
    end else begin
      q_step = step_r;
    end
  end

  always_comb begin
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    if (accept) begin
      if (in_final_req) begin
        prev_nxt      = '0;
        have_prev_nxt = 1'b0;
      end else begin
        prev_nxt      = in_sample;
        have_prev_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_ONE;
      prev_r      <= '0;
      have_prev_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        step_r <= cfg_step;
      end
      prev_r      <= prev_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

endmodule

FILE: design/lir_back.sv
// Back end of the resampler: walks the read position across each queued
// interval, then runs a multiply stage and a round stage into the output
// register. Uses lir_pkg.

module lir_back
  import lir_pkg::*;
#(
  parameter int SAMPLE_BITS  = 24,
  parameter int FRAC_BITS    = 16,
  parameter int MAX_UPSAMPLE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  output logic                                q_pop,
  input  lir_ctl_t                            q_ctl,
  input  logic signed [SAMPLE_BITS-1:0]       q_a,
  input  logic signed [SAMPLE_BITS:0]         q_diff,
  input  logic [FRAC_BITS+STEP_INT_BITS-1:0]  q_step,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_result,
  output logic                                out_run_end,
  output logic                                out_buffer_end
);

  localparam int STEP_W = FRAC_BITS + STEP_INT_BITS;
  localparam int CNT_W  = $clog2(MAX_UPSAMPLE + 1);
  localparam int PROD_W = SAMPLE_BITS + FRAC_BITS + 2;
  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(2 ** FRAC_BITS);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_UPSAMPLE);
  localparam logic [PROD_W-1:0] HALF     = PROD_W'(2 ** (FRAC_BITS - 1));

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_INTERP = 2'd1;
  localparam logic [1:0] S_TAIL   = 2'd2;

  // Sequencer state.
  logic [1:0]                    state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] a_r, a_nxt;
  logic signed [SAMPLE_BITS:0]   diff_r, diff_nxt;
  logic [STEP_W-1:0]             st_r, st_nxt;
  logic                          fin_r, fin_nxt;
  logic [STEP_W-1:0]             phase_r, phase_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;

  logic                          emit_ok, more_same, iss_valid, iss_ready;
  logic                          iss_last, iss_bend;
  logic [STEP_W-1:0]             p_next, p_after, entry_after;
  logic [CNT_W-1:0]              cnt_inc;
  logic signed [SAMPLE_BITS-1:0] iss_a;
  logic signed [SAMPLE_BITS:0]   iss_diff;
  logic signed [PROD_W-1:0]      prod;

  // Multiply stage.
  logic                          p1_valid_r;
  logic signed [PROD_W-1:0]      p1_prod_r;
  logic signed [SAMPLE_BITS-1:0] p1_a_r;
  logic                          p1_last_r, p1_bend_r;

  // Output register.
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_result_r;
  logic                          out_run_end_r, out_buffer_end_r;

  logic                          out_free;
  logic [PROD_W-1:0]             acc;

  assign emit_ok     = (phase_r < STEP_ONE) && (cnt_r < CNT_MAX);
  assign p_next      = phase_r + st_r;
  assign cnt_inc     = cnt_r + CNT_W'(1);
  assign more_same   = (p_next < STEP_ONE) && (cnt_inc < CNT_MAX);
  assign p_after     = (p_next >= STEP_ONE) ? p_next - STEP_ONE : '0;
  assign entry_after = (phase_r >= STEP_ONE) ? phase_r - STEP_ONE : '0;

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    diff_nxt  = diff_r;
    st_nxt    = st_r;
    fin_nxt   = fin_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    iss_valid = 1'b0;
    iss_last  = 1'b0;
    iss_bend  = 1'b0;
    iss_a     = a_r;
    iss_diff  = diff_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          a_nxt    = q_a;
          diff_nxt = q_diff;
          st_nxt   = q_step;
          fin_nxt  = q_ctl.fin;
          cnt_nxt  = '0;
          if (q_ctl.first) begin
            // The first sample of a buffer only opens an interval, unless it
            // also closes the buffer.
            phase_nxt = '0;
            state_nxt = q_ctl.fin ? S_TAIL : S_IDLE;
          end else begin
            state_nxt = S_INTERP;
          end
        end
      end
      S_INTERP: begin
        if (emit_ok) begin
          iss_valid = 1'b1;
          // The last interpolated word ends the run unless tail zeros follow.
          iss_last  = !more_same && !(fin_r && (p_after < STEP_ONE));
          iss_bend  = iss_last && fin_r;
          if (iss_ready) begin
            phase_nxt = p_next;
            cnt_nxt   = cnt_inc;
            if (!more_same) begin
              phase_nxt = p_after;
              cnt_nxt   = '0;
              state_nxt = fin_r ? S_TAIL : S_IDLE;
            end
          end
        end else begin
          phase_nxt = entry_after;
          cnt_nxt   = '0;
          state_nxt = fin_r ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL: begin
        iss_a    = '0;
        iss_diff = '0;
        if (emit_ok) begin
          iss_valid = 1'b1;
          iss_last  = !more_same;
          iss_bend  = !more_same;
          if (iss_ready) begin
            phase_nxt = p_next;
            cnt_nxt   = cnt_inc;
            if (!more_same) begin
              phase_nxt = '0;
              state_nxt = S_IDLE;
            end
          end
        end else begin
          phase_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign prod = iss_diff * $signed({1'b0, phase_r[FRAC_BITS-1:0]});

  assign out_free  = !out_valid_r || out_ready;
  assign iss_ready = !p1_valid_r || out_free;

  // Round half up: add one half and take the floor by dropping the fraction.
  assign acc = {{2{p1_a_r[SAMPLE_BITS-1]}}, p1_a_r, {FRAC_BITS{1'b0}}}
             + p1_prod_r + HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= '0;
      cnt_r       <= '0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      if (iss_ready) begin
        p1_valid_r <= iss_valid;
      end
      if (out_free) begin
        out_valid_r <= p1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    diff_r <= diff_nxt;
    st_r   <= st_nxt;
    fin_r  <= fin_nxt;
    if (iss_ready) begin
      p1_prod_r <= prod;
      p1_a_r    <= iss_a;
      p1_last_r <= iss_last;
      p1_bend_r <= iss_bend;
    end
    if (out_free && p1_valid_r) begin
      out_result_r     <= acc[FRAC_BITS +: SAMPLE_BITS];
      out_run_end_r    <= p1_last_r;
      out_buffer_end_r <= p1_bend_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result     = out_result_r;
  assign out_run_end    = out_run_end_r;
  assign out_buffer_end = out_buffer_end_r;

endmodule

FILE: design/linear_interp_resampler.sv
// Top level of the linear interpolation resampler.
// Depends on lir_pkg, lir_front, lir_fifo and lir_back.
//
// Usage:
//   in_*   : one input word per sample of the buffer; in_final_req marks the
//            last sample. Valid/ready handshake.
//   out_*  : interpolated words; out_run_end marks the last word caused by an
//            input word, out_buffer_end the last word of the buffer.
//   cfg_*  : write of the step register (Q5.16 by default, input rate over
//            output rate); cfg_ready is always high. Write it between buffers.
// Timing:
//   The back-end sequencer fetches each command in its idle state, then issues
//   one result per cycle while the multiply stage can take it. A word after
//   the first of a buffer passes through the interpolation state even when it
//   has no result, and a final word then issues any tail words from the tail
//   state. Results pass the multiply stage register, then the output register.
//   A two-entry queue lets the front keep accepting words while the back works.
// Reset: synchronous, active low; clears the step to 1.0, the previous sample,
//   the read position, the queue and the output register.
// Stall: when out_ready is low the output register and multiply stage hold,
//   the sequencer waits, and in_ready drops once the queue is full.

module linear_interp_resampler
  import lir_pkg::*;
#(
  parameter int SAMPLE_BITS  = 24,
  parameter int FRAC_BITS    = 16,
  parameter int MAX_UPSAMPLE = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic                                in_final_req,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [SAMPLE_BITS-1:0]       out_result,
  output logic                                out_run_end,
  output logic                                out_buffer_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [FRAC_BITS+STEP_INT_BITS-1:0]  cfg_step
);

  localparam int STEP_W = FRAC_BITS + STEP_INT_BITS;
  localparam int CTL_W  = $bits(lir_ctl_t);
  localparam int Q_W    = CTL_W + SAMPLE_BITS + (SAMPLE_BITS + 1) + STEP_W;

  logic                          fq_valid, fq_ready;
  lir_ctl_t                      fq_ctl;
  logic signed [SAMPLE_BITS-1:0] fq_a;
  logic signed [SAMPLE_BITS:0]   fq_diff;
  logic [STEP_W-1:0]             fq_step;

  logic                          bq_valid, bq_pop;
  logic [Q_W-1:0]                bq_data;
  lir_ctl_t                      bq_ctl;
  logic signed [SAMPLE_BITS-1:0] bq_a;
  logic signed [SAMPLE_BITS:0]   bq_diff;
  logic [STEP_W-1:0]             bq_step;

  lir_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .MAX_UPSAMPLE(MAX_UPSAMPLE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_sample   (in_sample),
    .in_final_req(in_final_req),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_step    (cfg_step),
    .q_valid     (fq_valid),
    .q_ready     (fq_ready),
    .q_ctl       (fq_ctl),
    .q_a         (fq_a),
    .q_diff      (fq_diff),
    .q_step      (fq_step)
  );

  lir_fifo #(
    .WIDTH(Q_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data ({fq_ctl, fq_a, fq_diff, fq_step}),
    .pop_valid (bq_valid),
    .pop_ready (bq_pop),
    .pop_data  (bq_data)
  );

  assign {bq_ctl, bq_a, bq_diff, bq_step} = bq_data;

  lir_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .MAX_UPSAMPLE(MAX_UPSAMPLE)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (bq_valid),
    .q_pop         (bq_pop),
    .q_ctl         (bq_ctl),
    .q_a           (bq_a),
    .q_diff        (bq_diff),
    .q_step        (bq_step),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result    (out_result),
    .out_run_end   (out_run_end),
    .out_buffer_end(out_buffer_end)
  );

endmodule

FILE: design/lir_checker.sv
// Port-level checks for the linear interpolation resampler, bound to the top.
// Depends only on the top level's ports.

module lir_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_result,
  input logic                   out_run_end,
  input logic                   out_buffer_end
);

  // A stalled result word holds its value.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result)
      && $stable(out_run_end) && $stable(out_buffer_end))
    else $error("stalled output word changed");

  // The last word of a buffer is also the last word of its input word.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_buffer_end |-> out_run_end)
    else $error("buffer end without run end");

  // Reset empties the output register.
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind linear_interp_resampler lir_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_lir_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_result    (out_result),
  .out_run_end   (out_run_end),
  .out_buffer_end(out_buffer_end)
);

FILE: tb/tb_linear_interp_resampler.sv
// Self-checking testbench for linear_interp_resampler: drives buffers of samples,
// predicts every interpolated word and compares what comes out, in order.
// Depends on lir_pkg and the linear_interp_resampler top level.

module tb_linear_interp_resampler;
  import lir_pkg::*;

  localparam int SAMPLE_W    = 24;
  localparam int FRAC_W      = 16;
  localparam int MAX_UP      = 16;
  localparam int STEP_W      = FRAC_W + STEP_INT_BITS;
  localparam longint ONE_POS = 64'd1 << FRAC_W;
  localparam longint STEP_LO = (ONE_POS + MAX_UP - 1) / MAX_UP;
  localparam longint STEP_HI = 64'd16 << FRAC_W;
  localparam int SETTLE      = 40;
  localparam int HOLD_CYCLES = 300;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [STEP_W-1:0] STEP_ALL_ONES = '1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] result;
    logic                       run_end;
    logic                       buffer_end;
  } out_word_t;

  class resample_scoreboard;
    out_word_t       due_words[$];
    bit [STEP_W-1:0] step_word;
    longint          last_in;
    bit              have_last;
    longint          read_pos;
    int              mismatches;

    function new();
      step_word  = STEP_W'(ONE_POS);
      last_in    = 0;
      have_last  = 1'b0;
      read_pos   = 0;
      mismatches = 0;
    endfunction

    // Round half up: floor((a*2^F + (b-a)*f + 2^(F-1)) / 2^F).
    function longint lerp(longint a, longint b, longint f);
      longint acc;
      acc = a * ONE_POS + (b - a) * f + (ONE_POS >> 1);
      return acc >>> FRAC_W;
    endfunction

    function void push_word(longint v);
      out_word_t w;
      w.result     = SAMPLE_W'(v);
      w.run_end    = 1'b0;
      w.buffer_end = 1'b0;
      due_words.push_back(w);
    endfunction

    // Called once per accepted input word.
    function void take_sample(logic signed [SAMPLE_W-1:0] s, logic fin);
      longint cur;
      longint st;
      int     n;
      int     last;
      cur = s;
      st  = step_word;
      n   = 0;
      if (st < STEP_LO) st = STEP_LO;
      if (st > STEP_HI) st = STEP_HI;
      if (!have_last) begin
        last_in   = cur;
        have_last = 1'b1;
        read_pos  = 0;
      end else begin
        for (int c = 0; read_pos < ONE_POS && c < MAX_UP; c++) begin
          push_word(lerp(last_in, cur, read_pos));
          read_pos += st;
          n++;
        end
        read_pos = (read_pos >= ONE_POS) ? read_pos - ONE_POS : 0;
        last_in  = cur;
      end
      if (fin) begin
        // Tail positions past the last sample come out as zeros.
        for (int c = 0; read_pos < ONE_POS && c < MAX_UP; c++) begin
          push_word(0);
          read_pos += st;
          n++;
        end
        last_in   = 0;
        have_last = 1'b0;
        read_pos  = 0;
      end
      if (n > 0) begin
        last = due_words.size() - 1;
        due_words[last].run_end = 1'b1;
        if (fin) due_words[last].buffer_end = 1'b1;
      end
    endfunction

    function void check_word(logic signed [SAMPLE_W-1:0] r, logic re, logic be);
      out_word_t want;
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: result %0d run_end %0b buffer_end %0b", r, re, be);
        return;
      end
      want = due_words.pop_front();
      if (want.result !== r || want.run_end !== re || want.buffer_end !== be) begin
        mismatches++;
        if (mismatches <= 10)
          $display("word mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                   want.result, want.run_end, want.buffer_end, r, re, be);
      end
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic                       in_final_req;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_result;
  logic                       out_run_end;
  logic                       out_buffer_end;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [STEP_W-1:0]          cfg_step;

  resample_scoreboard sb;
  int burst_left;
  bit hold_req;
  bit hold_done;

  linear_interp_resampler #(
    .SAMPLE_BITS(SAMPLE_W),
    .FRAC_BITS(FRAC_W),
    .MAX_UPSAMPLE(MAX_UP)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_sample(in_sample),
    .in_final_req(in_final_req),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_result(out_result),
    .out_run_end(out_run_end),
    .out_buffer_end(out_buffer_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_step(cfg_step)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_word(out_result, out_run_end, out_buffer_end);
    end
  end

  // The receiver cycles through stall patterns, and holds off once for a long
  // stretch so that the queue fills and the input side backs up.
  initial begin
    int cyc;
    cyc = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        case ((cyc >> 7) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    logic signed [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = SAMPLE_MIN;
      1: v = SAMPLE_MAX;
      2, 3: begin
        v = SAMPLE_W'($urandom_range(0, 2000));
        v = v - 1000;
      end
      default: v = SAMPLE_W'($urandom);
    endcase
    return v;
  endfunction

  // Offers one word in the current burst; a new burst starts after a gap.
  task automatic offer(input logic signed [SAMPLE_W-1:0] s, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_final_req <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_sample(s, fin);
  endtask

  task automatic send_buffer(input int len);
    for (int i = 0; i < len; i++) begin
      offer(draw_sample(), i == len - 1);
    end
  endtask

  // The step register is only written once every expected word is out and
  // words that cause no output have had time to drain.
  task automatic write_step(input logic [STEP_W-1:0] v);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_step  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.step_word = v;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int sent;
    int len;
    int waited;
    sb = new();
    burst_left = 0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_sample    <= '0;
    in_final_req <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_step     <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset step of 1.0: a one-sample buffer gives only its tail zero.
    offer(SAMPLE_MIN, 1'b1);
    offer(SAMPLE_MAX, 1'b0);
    offer(SAMPLE_MIN, 1'b0);
    offer(SAMPLE_MAX, 1'b0);
    offer('0, 1'b1);

    // A step below the minimum saturates to the deepest upsampling, so the
    // final word yields a full interval plus a full tail.
    write_step('0);
    offer(SAMPLE_MIN, 1'b0);
    offer(SAMPLE_MAX, 1'b0);
    offer(24'sd123, 1'b1);

    // A step above the maximum saturates; the final word here has no output.
    write_step(STEP_ALL_ONES);
    for (int i = 1; i <= 5; i++) offer(SAMPLE_W'(i), i == 5);

    // Step changed in the middle of a buffer.
    write_step(STEP_W'(98304));
    offer(24'sd1000, 1'b0);
    offer(-24'sd1000, 1'b0);
    write_step(STEP_W'(40000));
    offer(24'sd5000, 1'b0);
    offer(24'sd7, 1'b1);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_step(STEP_W'(STEP_LO));
        1: write_step(STEP_W'(STEP_HI));
        2: write_step(STEP_W'($urandom_range(4096, 131072)));
        3: write_step(STEP_W'($urandom));
        default: write_step(STEP_W'($urandom_range(32768, 196608)));
      endcase
      if (ph == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < 24) begin
        len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 10);
        send_buffer(len);
        sent += len;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (sb.due_words.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
